// ----- rtl/ccr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ccr_pkg;
	localparam int DataW  = 32;
	localparam int FracW  = 16;
	localparam int LenW   = 31;
	localparam int CoefW  = 17;
	localparam int GainW  = 19;
	localparam int IdxW   = 3;
	localparam int CfgW   = 31;
	localparam int RootW  = 32;
	localparam int QuotW  = 31;
	localparam int InW    = 256;
	localparam int OutW   = 200;

	localparam logic [LenW-1:0]  HalfXRst  = 31'd83231;
	localparam logic [LenW-1:0]  HalfYRst  = 31'd41615;
	localparam logic [LenW-1:0]  RadiusRst = 31'd1873;
	localparam logic [CoefW-1:0] FricRst   = 17'd13107;
	localparam logic [CoefW-1:0] RestRst   = 17'd49152;

	typedef enum logic [IdxW-1:0] {
		REG_HALF_X,
		REG_HALF_Y,
		REG_RADIUS,
		REG_FRICTION,
		REG_RESTITUTION
	} reg_idx_t;

	typedef enum logic [2:0] {
		RAIL_NONE,
		RAIL_XP,
		RAIL_XN,
		RAIL_YP,
		RAIL_YN
	} rail_t;

	typedef struct packed {
		logic [2:0][31:0]    vel;
		logic [2:0][31:0]    spin;
		logic                contact;
		logic                near;
		logic                axis_y;
		logic                s_neg;
		logic                sig_neg;
		logic signed [32:0]  vn;
		logic signed [63:0]  pa_t;
		logic signed [63:0]  pa_z;
		logic signed [52:0]  gv;
		logic signed [50:0]  rv;
		logic signed [31:0]  ut;
		logic signed [31:0]  uz;
		logic signed [31:0]  vn_new;
		logic [30:0]         itr_v;
		logic [63:0]         sq_t;
		logic [63:0]         sq_z;
		logic [63:0]         cap2;
		logic [63:0]         mag2;
		logic                under;
		logic                zero;
		logic [64:0]         rem;
		logic [31:0]         root;
		logic [63:0]         rt;
		logic [63:0]         rz;
		logic [30:0]         qt;
		logic [30:0]         qz;
		logic signed [31:0]  it;
		logic signed [31:0]  iz;
		logic signed [35:0]  ct;
		logic signed [35:0]  cz;
	} item_t;

	function automatic logic signed [31:0] sat(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7fffffff;
		if (x < -64'sd2147483648)
			return 32'sh80000000;
		return x[31:0];
	endfunction
endpackage
`default_nettype wire

// ----- rtl/cushion_collision_response.sv -----
// Throughput: one request per cycle; the pipeline advances whenever the
// output register is empty or its result is taken.
// The 32-step root extraction and the 31-step quotient stages set the depth.
// Reset (arst_n low) clears all valid bits and restores register defaults.
`timescale 1ns / 1ps
`default_nettype none
module cushion_collision_response (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_we,
	input  wire [ccr_pkg::IdxW-1:0]               cfg_addr,
	input  wire [ccr_pkg::CfgW-1:0]               cfg_wdata,
	// pos_x, pos_y, vel_x, vel_y, vel_z, spin_x, spin_y, spin_z
	input  wire [ccr_pkg::InW-1:0]                s_axis_tdata,
	input  wire                                   s_axis_tvalid,
	output logic                                  s_axis_tready,
	// new_vel_x, new_vel_y, new_vel_z, new_spin_x, new_spin_y, new_spin_z,
	// rail_contact, near_other_rail, pocketed, zero fill
	output logic [ccr_pkg::OutW-1:0]              m_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  wire                                   m_axis_tready
);
	localparam int Sq = ccr_pkg::RootW;
	localparam int Dv = ccr_pkg::QuotW;
	localparam int Fr = ccr_pkg::FracW;

	logic [ccr_pkg::LenW-1:0]  hx_q, hy_q, rad_q;
	logic [ccr_pkg::CoefW-1:0] rf_q, re_q;
	logic [ccr_pkg::GainW-1:0] gain_q;
	logic                      en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hx_q  <= ccr_pkg::HalfXRst;
			hy_q  <= ccr_pkg::HalfYRst;
			rad_q <= ccr_pkg::RadiusRst;
			rf_q  <= ccr_pkg::FricRst;
			re_q  <= ccr_pkg::RestRst;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ccr_pkg::REG_HALF_X:      hx_q  <= cfg_wdata[ccr_pkg::LenW-1:0];
				ccr_pkg::REG_HALF_Y:      hy_q  <= cfg_wdata[ccr_pkg::LenW-1:0];
				ccr_pkg::REG_RADIUS:      rad_q <= cfg_wdata[ccr_pkg::LenW-1:0];
				ccr_pkg::REG_FRICTION:    rf_q  <= cfg_wdata[ccr_pkg::CoefW-1:0];
				ccr_pkg::REG_RESTITUTION: re_q  <= cfg_wdata[ccr_pkg::CoefW-1:0];
				default: ;
			endcase
		end
	end

	logic [34:0] gain_full;
	assign gain_full = 35'(rf_q) * (35'(re_q) + 35'd65536);

	always_ff @(posedge clk) begin
		gain_q <= gain_full[Fr +: ccr_pkg::GainW];
	end

	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	ccr_pkg::item_t p_s1, p_s2, p_s3, p_s4, p_s5, p_s7, p_s9, n_s1, n_s2, n_s3, n_s4, n_s5;
	ccr_pkg::item_t n_s7, n_s9;
	ccr_pkg::item_t p_sq [Sq];
	ccr_pkg::item_t p_dv [Dv];
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s7, vld_s9;
	logic [Sq-1:0] vld_sq;
	logic [Dv-1:0] vld_dv;

	// classify rails
	always_comb begin
		logic signed [33:0] px, py, hx, hy, ra, ra2, apy;
		logic signed [31:0] vx, vy, vax;
		logic c_xp, c_xn, c_yp, c_yn, m_xp, m_xn, m_yp, m_yn;
		ccr_pkg::rail_t rail;
		px  = 34'(signed'(s_axis_tdata[31:0]));
		py  = 34'(signed'(s_axis_tdata[63:32]));
		vx  = signed'(s_axis_tdata[95:64]);
		vy  = signed'(s_axis_tdata[127:96]);
		hx  = signed'({3'b0, hx_q});
		hy  = signed'({3'b0, hy_q});
		ra  = signed'({3'b0, rad_q});
		ra2 = ra <<< 1;
		apy = py[33] ? -py : py;
		c_xp = (hx - px < ra) && (vx > 0);
		c_xn = (hx + px < ra) && (vx < 0);
		c_yp = (hy - py < ra) && (vy > 0);
		c_yn = (hy + py < ra) && (vy < 0);
		m_xp = (hx - px < ra2) && (vx > 0);
		m_xn = (hx + px < ra2) && (vx < 0);
		m_yp = (hy - py < ra2) && (vy > 0);
		m_yn = (hy + py < ra2) && (vy < 0);
		rail = ccr_pkg::RAIL_NONE;
		if (c_xp)
			rail = ccr_pkg::RAIL_XP;
		if (c_xn)
			rail = ccr_pkg::RAIL_XN;
		if (c_yp)
			rail = ccr_pkg::RAIL_YP;
		if (c_yn)
			rail = ccr_pkg::RAIL_YN;
		n_s1 = '0;
		for (int c = 0; c < 3; c++) begin
			n_s1.vel[c]  = s_axis_tdata[64 + 32*c +: 32];
			n_s1.spin[c] = s_axis_tdata[160 + 32*c +: 32];
		end
		n_s1.contact = rail != ccr_pkg::RAIL_NONE;
		n_s1.near = (m_xp && rail != ccr_pkg::RAIL_XP) || (m_xn && rail != ccr_pkg::RAIL_XN)
			|| (m_yp && rail != ccr_pkg::RAIL_YP) || (m_yn && rail != ccr_pkg::RAIL_YN)
			|| ((apy < ra) && (rail == ccr_pkg::RAIL_NONE || rail == ccr_pkg::RAIL_XP
			|| rail == ccr_pkg::RAIL_XN));
		n_s1.axis_y  = rail == ccr_pkg::RAIL_YP || rail == ccr_pkg::RAIL_YN;
		n_s1.s_neg   = rail == ccr_pkg::RAIL_XN || rail == ccr_pkg::RAIL_YN;
		n_s1.sig_neg = n_s1.axis_y ^ n_s1.s_neg;
		vax = n_s1.axis_y ? vy : vx;
		n_s1.vn = n_s1.s_neg ? -33'(vax) : 33'(vax);
	end

	// slip products, cap product and restitution product
	always_comb begin
		logic signed [32:0] wt, wz, mt, mz, ra;
		logic signed [64:0] pt, pz;
		n_s2 = p_s1;
		ra = signed'({2'b0, rad_q});
		wt = 33'(signed'(p_s1.axis_y ? p_s1.spin[0] : p_s1.spin[1]));
		wz = 33'(signed'(p_s1.spin[2]));
		mt = p_s1.sig_neg ? -wz : wz;
		mz = p_s1.sig_neg ? wt : -wt;
		pt = 65'(ra) * 65'(mt);
		pz = 65'(ra) * 65'(mz);
		n_s2.pa_t = pt[63:0];
		n_s2.pa_z = pz[63:0];
		n_s2.gv   = 53'(signed'({1'b0, gain_q})) * 53'(p_s1.vn);
		n_s2.rv   = 51'(signed'({1'b0, re_q})) * 51'(p_s1.vn);
	end

	// slip vector, cap and new normal speed
	always_comb begin
		logic signed [63:0] vt, vz, cap, rn;
		logic signed [31:0] cs;
		n_s3 = p_s2;
		vt = 64'(signed'(p_s2.axis_y ? p_s2.vel[0] : p_s2.vel[1]));
		vz = 64'(signed'(p_s2.vel[2]));
		n_s3.ut = ccr_pkg::sat(vt + (p_s2.pa_t >>> Fr));
		n_s3.uz = ccr_pkg::sat(vz + (p_s2.pa_z >>> Fr));
		cap = 64'(p_s2.gv >>> Fr);
		cs  = ccr_pkg::sat(cap);
		n_s3.itr_v = cs[30:0];
		rn = 64'(p_s2.rv >>> Fr);
		n_s3.vn_new = ccr_pkg::sat(-rn);
	end

	// squares
	always_comb begin
		logic signed [63:0] st, sz;
		n_s4 = p_s3;
		st = 64'(p_s3.ut) * 64'(p_s3.ut);
		sz = 64'(p_s3.uz) * 64'(p_s3.uz);
		n_s4.sq_t = st;
		n_s4.sq_z = sz;
		n_s4.cap2 = 64'(p_s3.itr_v) * 64'(p_s3.itr_v);
	end

	always_comb begin
		n_s5 = p_s4;
		n_s5.mag2  = p_s4.sq_t + p_s4.sq_z;
		n_s5.under = n_s5.mag2 < p_s4.cap2;
		n_s5.zero  = n_s5.mag2 == 64'd0;
		n_s5.rem   = {1'b0, n_s5.mag2};
		n_s5.root  = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1 <= n_s1;
			p_s2 <= n_s2;
			p_s3 <= n_s3;
			p_s4 <= n_s4;
			p_s5 <= n_s5;
			p_s7 <= n_s7;
			p_s9 <= n_s9;
		end
	end

	// square root, one result bit per stage
	for (genvar g = 0; g < Sq; g++) begin : g_sqrt
		localparam int B = Sq - 1 - g;
		ccr_pkg::item_t prv, nxt;
		logic [64:0] delta;
		assign prv = (g == 0) ? p_s5 : p_sq[(g == 0) ? 0 : g - 1];
		always_comb begin
			nxt   = prv;
			delta = ({33'b0, prv.root} << (B + 1)) | (65'd1 << (2 * B));
			if (prv.rem >= delta) begin
				nxt.rem     = prv.rem - delta;
				nxt.root[B] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en)
				p_sq[g] <= nxt;
		end
	end

	// numerators for the capped impulse
	always_comb begin
		logic [31:0] at, az;
		n_s7 = p_sq[Sq-1];
		at = p_sq[Sq-1].ut[31] ? 32'(-p_sq[Sq-1].ut) : 32'(p_sq[Sq-1].ut);
		az = p_sq[Sq-1].uz[31] ? 32'(-p_sq[Sq-1].uz) : 32'(p_sq[Sq-1].uz);
		n_s7.rt = 64'(at) * 64'(p_sq[Sq-1].itr_v);
		n_s7.rz = 64'(az) * 64'(p_sq[Sq-1].itr_v);
		n_s7.qt = '0;
		n_s7.qz = '0;
	end

	// restoring division, one quotient bit per stage
	for (genvar g = 0; g < Dv; g++) begin : g_div
		localparam int J = Dv - 1 - g;
		ccr_pkg::item_t prv, nxt;
		logic [63:0] dsh;
		assign prv = (g == 0) ? p_s7 : p_dv[(g == 0) ? 0 : g - 1];
		always_comb begin
			nxt = prv;
			dsh = {32'b0, prv.root} << J;
			if (prv.rt >= dsh) begin
				nxt.rt    = prv.rt - dsh;
				nxt.qt[J] = 1'b1;
			end
			if (prv.rz >= dsh) begin
				nxt.rz    = prv.rz - dsh;
				nxt.qz[J] = 1'b1;
			end
		end
		always_ff @(posedge clk) begin
			if (en)
				p_dv[g] <= nxt;
		end
	end

	// impulse and spin terms
	always_comb begin
		ccr_pkg::item_t d;
		logic signed [35:0] ft, fz;
		d = p_dv[Dv-1];
		n_s9 = d;
		if (d.under) begin
			n_s9.it = d.ut;
			n_s9.iz = d.uz;
		end else if (d.zero) begin
			n_s9.it = '0;
			n_s9.iz = '0;
		end else begin
			n_s9.it = d.ut[31] ? -signed'({1'b0, d.qt}) : signed'({1'b0, d.qt});
			n_s9.iz = d.uz[31] ? -signed'({1'b0, d.qz}) : signed'({1'b0, d.qz});
		end
		ft = 36'(n_s9.iz) * 36'sd5;
		fz = 36'(n_s9.it) * 36'sd5;
		n_s9.ct = (d.sig_neg ? -ft : ft) >>> 1;
		n_s9.cz = (d.sig_neg ? fz : -fz) >>> 1;
	end

	// apply response and drive the output register
	logic [ccr_pkg::OutW-1:0] n_out;
	always_comb begin
		logic signed [63:0] vt, vz, wt, wz;
		logic signed [31:0] nv_n, nv_t, nv_z, nw_t, nw_z;
		logic [2:0][31:0] ov, ow;
		vt = 64'(signed'(p_s9.axis_y ? p_s9.vel[0] : p_s9.vel[1]));
		vz = 64'(signed'(p_s9.vel[2]));
		wt = 64'(signed'(p_s9.axis_y ? p_s9.spin[0] : p_s9.spin[1]));
		wz = 64'(signed'(p_s9.spin[2]));
		nv_n = ccr_pkg::sat(p_s9.s_neg ? -64'(p_s9.vn_new) : 64'(p_s9.vn_new));
		nv_t = ccr_pkg::sat(vt - 64'(p_s9.it));
		nv_z = ccr_pkg::sat(vz - 64'(p_s9.iz));
		nw_t = ccr_pkg::sat(wt - 64'(p_s9.ct));
		nw_z = ccr_pkg::sat(wz - 64'(p_s9.cz));
		ov = p_s9.vel;
		ow = p_s9.spin;
		if (p_s9.contact) begin
			ov[2] = nv_z;
			ow[2] = nw_z;
			if (p_s9.axis_y) begin
				ov[0] = nv_t;
				ov[1] = nv_n;
				ow[0] = nw_t;
			end else begin
				ov[0] = nv_n;
				ov[1] = nv_t;
				ow[1] = nw_t;
			end
		end
		n_out = {5'b0, p_s9.contact && p_s9.near, p_s9.near, p_s9.contact, ow, ov};
	end

	always_ff @(posedge clk) begin
		if (en)
			m_axis_tdata <= n_out;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1        <= 1'b0;
			vld_s2        <= 1'b0;
			vld_s3        <= 1'b0;
			vld_s4        <= 1'b0;
			vld_s5        <= 1'b0;
			vld_sq        <= '0;
			vld_s7        <= 1'b0;
			vld_dv        <= '0;
			vld_s9        <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else if (en) begin
			vld_s1        <= s_axis_tvalid;
			vld_s2        <= vld_s1;
			vld_s3        <= vld_s2;
			vld_s4        <= vld_s3;
			vld_s5        <= vld_s4;
			vld_sq        <= {vld_sq[Sq-2:0], vld_s5};
			vld_s7        <= vld_sq[Sq-1];
			vld_dv        <= {vld_dv[Dv-2:0], vld_s7};
			vld_s9        <= vld_dv[Dv-1];
			m_axis_tvalid <= vld_s9;
		end
	end
endmodule
`default_nettype wire
